@@ rtl/refract_vector_macros.svh @@
// Assertion macros for the refraction pipeline.
`ifndef REFRACT_VECTOR_MACROS_SVH
`define REFRACT_VECTOR_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define RFV_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define RFV_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/rfv_pkg.sv @@
// Constants, widths and types of the vector refraction pipeline.
package rfv_pkg;

    function automatic int imax(input int a, input int b);
        return (a > b) ? a : b;
    endfunction

    localparam int FRAC_BITS = 14;
    localparam int IN_W      = 16;
    localparam int ETA_W     = 16;
    localparam int OUT_W     = 20;

    localparam int PRD_W  = 2 * IN_W;
    localparam int DOT_W  = PRD_W + 1;
    localparam int D_W    = DOT_W - FRAC_BITS;
    localparam int DD_W   = 2 * D_W;
    localparam int DDF_W  = DD_W - FRAC_BITS;
    localparam int U_W    = imax(DDF_W, FRAC_BITS + 2) + 1;
    localparam int EE_W   = 2 * ETA_W;
    localparam int E2_W   = EE_W - FRAC_BITS;
    localparam int P_W    = E2_W + 1 + U_W;
    localparam int PX_W   = imax(P_W, 64);
    localparam int PC_W   = (P_W > 63) ? 64 : P_W;
    localparam int KS_W   = PC_W - FRAC_BITS;
    localparam int K_W    = imax(KS_W, FRAC_BITS + 2) + 1;
    localparam int SQ_PER = 3;
    localparam int ROOT_W = ((((K_W - 1 + FRAC_BITS + 1) / 2) + SQ_PER - 1) / SQ_PER) * SQ_PER;
    localparam int RAD_W  = 2 * ROOT_W;
    localparam int REM_W  = ROOT_W + 2;
    localparam int SQ_STG = ROOT_W / SQ_PER;
    localparam int ED_W   = ETA_W + 1 + D_W;
    localparam int EDF_W  = ED_W - FRAC_BITS;
    localparam int S_W    = imax(EDF_W, ROOT_W + 1) + 1;
    localparam int EI_W   = ETA_W + 1 + IN_W;
    localparam int NS_W   = IN_W + S_W;
    localparam int C_W    = imax(EI_W, NS_W) + 1;
    localparam int CF_W   = C_W - FRAC_BITS;

    localparam int ONE = 1 << FRAC_BITS;
    localparam logic signed [63:0] PROD_LIM = 64'sd1 <<< 62;

    typedef struct packed {
        logic signed [EI_W-1:0]  eta_ix;
        logic signed [EI_W-1:0]  eta_iy;
        logic signed [EI_W-1:0]  eta_iz;
        logic signed [IN_W-1:0]  nx;
        logic signed [IN_W-1:0]  ny;
        logic signed [IN_W-1:0]  nz;
        logic signed [EDF_W-1:0] edf;
        logic                    tir;
    } t_sq_side;

endpackage

@@ rtl/rfv_if.sv @@
// Valid/ready channel interfaces for the refraction inputs and results.
interface rfv_in_if;
    logic                             valid;
    logic                             ready;
    logic signed [rfv_pkg::IN_W-1:0]  incident_x;
    logic signed [rfv_pkg::IN_W-1:0]  incident_y;
    logic signed [rfv_pkg::IN_W-1:0]  incident_z;
    logic signed [rfv_pkg::IN_W-1:0]  normal_x;
    logic signed [rfv_pkg::IN_W-1:0]  normal_y;
    logic signed [rfv_pkg::IN_W-1:0]  normal_z;
    logic        [rfv_pkg::ETA_W-1:0] eta;

    modport source (
        output valid, incident_x, incident_y, incident_z,
        output normal_x, normal_y, normal_z, eta,
        input  ready
    );
    modport sink (
        input  valid, incident_x, incident_y, incident_z,
        input  normal_x, normal_y, normal_z, eta,
        output ready
    );
endinterface

interface rfv_out_if;
    logic                             valid;
    logic                             ready;
    logic signed [rfv_pkg::OUT_W-1:0] refracted_x;
    logic signed [rfv_pkg::OUT_W-1:0] refracted_y;
    logic signed [rfv_pkg::OUT_W-1:0] refracted_z;
    logic                             total_reflection;
    logic                             clipped;

    modport source (
        output valid, refracted_x, refracted_y, refracted_z,
        output total_reflection, clipped,
        input  ready
    );
    modport sink (
        input  valid, refracted_x, refracted_y, refracted_z,
        input  total_reflection, clipped,
        output ready
    );
endinterface

@@ rtl/rfv_sqrt.sv @@
// Pipelined integer square root, a few root bits per stage, with side data.
module rfv_sqrt (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_vld,
    input  logic [rfv_pkg::RAD_W-1:0]    i_rad,
    input  rfv_pkg::t_sq_side            i_side,
    output logic                         o_vld,
    output logic [rfv_pkg::ROOT_W-1:0]   o_root,
    output rfv_pkg::t_sq_side            o_side
);

    logic                         s_vld  [rfv_pkg::SQ_STG+1];
    logic [rfv_pkg::REM_W-1:0]    s_rem  [rfv_pkg::SQ_STG+1];
    logic [rfv_pkg::ROOT_W-1:0]   s_root [rfv_pkg::SQ_STG+1];
    logic [rfv_pkg::RAD_W-1:0]    s_rad  [rfv_pkg::SQ_STG+1];
    rfv_pkg::t_sq_side            s_side [rfv_pkg::SQ_STG+1];

    assign s_vld[0]  = i_vld;
    assign s_rem[0]  = '0;
    assign s_root[0] = '0;
    assign s_rad[0]  = i_rad;
    assign s_side[0] = i_side;

    for (genvar g = 0; g < rfv_pkg::SQ_STG; g++) begin : g_stg
        logic                       r_vld;
        logic [rfv_pkg::REM_W-1:0]  r_rem;
        logic [rfv_pkg::ROOT_W-1:0] r_root;
        logic [rfv_pkg::RAD_W-1:0]  r_rad;
        rfv_pkg::t_sq_side          r_side;
        logic [rfv_pkg::REM_W-1:0]  n_rem;
        logic [rfv_pkg::ROOT_W-1:0] n_root;
        logic [rfv_pkg::RAD_W-1:0]  n_rad;

        always_comb begin : p_iter
            logic [rfv_pkg::REM_W-1:0]  v_rem;
            logic [rfv_pkg::REM_W-1:0]  v_test;
            logic [rfv_pkg::ROOT_W-1:0] v_root;
            logic [rfv_pkg::RAD_W-1:0]  v_rad;
            v_rem  = s_rem[g];
            v_root = s_root[g];
            v_rad  = s_rad[g];
            for (int j = 0; j < rfv_pkg::SQ_PER; j++) begin
                v_rem  = {v_rem[rfv_pkg::REM_W-3:0], v_rad[rfv_pkg::RAD_W-1 -: 2]};
                v_rad  = v_rad << 2;
                v_test = {v_root, 2'b01};
                if (v_rem >= v_test) begin
                    v_rem  = v_rem - v_test;
                    v_root = {v_root[rfv_pkg::ROOT_W-2:0], 1'b1};
                end else begin
                    v_root = {v_root[rfv_pkg::ROOT_W-2:0], 1'b0};
                end
            end
            n_rem  = v_rem;
            n_root = v_root;
            n_rad  = v_rad;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld <= 1'b0;
            end else if (i_en) begin
                r_vld <= s_vld[g];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem  <= n_rem;
                r_root <= n_root;
                r_rad  <= n_rad;
                r_side <= s_side[g];
            end
        end

        assign s_vld[g+1]  = r_vld;
        assign s_rem[g+1]  = r_rem;
        assign s_root[g+1] = r_root;
        assign s_rad[g+1]  = r_rad;
        assign s_side[g+1] = r_side;
    end

    assign o_vld  = s_vld[rfv_pkg::SQ_STG];
    assign o_root = s_root[rfv_pkg::SQ_STG];
    assign o_side = s_side[rfv_pkg::SQ_STG];

endmodule

@@ rtl/refract_vector.sv @@
// Top level of the vector refraction pipeline (Snell's law, fixed point).
//
//   Port    | Role   | Transaction contents
//   --------+--------+----------------------------------------------------------
//   i_in    | sink   | incident x/y/z, normal x/y/z (Q2.14), eta (unsigned Q2.14)
//   o_out   | source | refracted x/y/z (Q6.14), total_reflection, clipped
//
// One transaction is accepted per cycle while the pipeline is not held; results
// pass through stages 1 to 5, the square root stages, which resolve three root
// bits each, then stage 6 and the output register.
// Reset clears only the stage valid bits.
// The whole pipeline advances together; it holds when the output register is
// full and the sink is not ready, so nothing is dropped or repeated.
`include "refract_vector_macros.svh"

module refract_vector (
    input  logic      i_clk,
    input  logic      i_rst_n,
    rfv_in_if.sink    i_in,
    rfv_out_if.source o_out
);

    function automatic logic [rfv_pkg::OUT_W:0] sat_c(
        input logic signed [rfv_pkg::CF_W-1:0] v
    );
        logic signed [rfv_pkg::CF_W-1:0] v_max;
        logic signed [rfv_pkg::CF_W-1:0] v_min;
        v_max = rfv_pkg::CF_W'({1'b0, {(rfv_pkg::OUT_W-1){1'b1}}});
        v_min = rfv_pkg::CF_W'($signed({1'b1, {(rfv_pkg::OUT_W-1){1'b0}}}));
        if (v > v_max) begin
            return {1'b1, 1'b0, {(rfv_pkg::OUT_W-1){1'b1}}};
        end else if (v < v_min) begin
            return {1'b1, 1'b1, {(rfv_pkg::OUT_W-1){1'b0}}};
        end
        return {1'b0, v[rfv_pkg::OUT_W-1:0]};
    endfunction

    logic en;
    logic r_out_vld;

    assign en         = !r_out_vld || o_out.ready;
    assign i_in.ready = en;

    // Stage 1: input products.
    logic                              r1_vld;
    logic signed [rfv_pkg::PRD_W-1:0]  r1_pxx, r1_pyy, r1_pzz;
    logic        [rfv_pkg::EE_W-1:0]   r1_ee;
    logic signed [rfv_pkg::EI_W-1:0]   r1_eix, r1_eiy, r1_eiz;
    logic        [rfv_pkg::ETA_W-1:0]  r1_eta;
    logic signed [rfv_pkg::IN_W-1:0]   r1_nx, r1_ny, r1_nz;
    logic signed [rfv_pkg::ETA_W:0]    w_eta_s;

    assign w_eta_s = $signed({1'b0, i_in.eta});

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_pxx <= rfv_pkg::PRD_W'(i_in.incident_x) * rfv_pkg::PRD_W'(i_in.normal_x);
            r1_pyy <= rfv_pkg::PRD_W'(i_in.incident_y) * rfv_pkg::PRD_W'(i_in.normal_y);
            r1_pzz <= rfv_pkg::PRD_W'(i_in.incident_z) * rfv_pkg::PRD_W'(i_in.normal_z);
            r1_ee  <= rfv_pkg::EE_W'(i_in.eta) * rfv_pkg::EE_W'(i_in.eta);
            r1_eix <= rfv_pkg::EI_W'(w_eta_s) * rfv_pkg::EI_W'(i_in.incident_x);
            r1_eiy <= rfv_pkg::EI_W'(w_eta_s) * rfv_pkg::EI_W'(i_in.incident_y);
            r1_eiz <= rfv_pkg::EI_W'(w_eta_s) * rfv_pkg::EI_W'(i_in.incident_z);
            r1_eta <= i_in.eta;
            r1_nx  <= i_in.normal_x;
            r1_ny  <= i_in.normal_y;
            r1_nz  <= i_in.normal_z;
        end
    end

    // Stage 2: dot product and eta squared.
    logic                              r2_vld;
    logic signed [rfv_pkg::DOT_W-1:0]  w_dot;
    logic signed [rfv_pkg::D_W-1:0]    r2_d;
    logic        [rfv_pkg::E2_W-1:0]   r2_e2;
    logic        [rfv_pkg::ETA_W-1:0]  r2_eta;
    logic signed [rfv_pkg::EI_W-1:0]   r2_eix, r2_eiy, r2_eiz;
    logic signed [rfv_pkg::IN_W-1:0]   r2_nx, r2_ny, r2_nz;

    assign w_dot = rfv_pkg::DOT_W'(r1_pxx) + rfv_pkg::DOT_W'(r1_pyy)
                 + rfv_pkg::DOT_W'(r1_pzz);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_d   <= rfv_pkg::D_W'(w_dot >>> rfv_pkg::FRAC_BITS);
            r2_e2  <= rfv_pkg::E2_W'(r1_ee >> rfv_pkg::FRAC_BITS);
            r2_eta <= r1_eta;
            r2_eix <= r1_eix;
            r2_eiy <= r1_eiy;
            r2_eiz <= r1_eiz;
            r2_nx  <= r1_nx;
            r2_ny  <= r1_ny;
            r2_nz  <= r1_nz;
        end
    end

    // Stage 3: dot squared and eta times dot.
    logic                              r3_vld;
    logic signed [rfv_pkg::DD_W-1:0]   r3_dd;
    logic signed [rfv_pkg::ED_W-1:0]   r3_ed;
    logic        [rfv_pkg::E2_W-1:0]   r3_e2;
    logic signed [rfv_pkg::EI_W-1:0]   r3_eix, r3_eiy, r3_eiz;
    logic signed [rfv_pkg::IN_W-1:0]   r3_nx, r3_ny, r3_nz;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_dd  <= rfv_pkg::DD_W'(r2_d) * rfv_pkg::DD_W'(r2_d);
            r3_ed  <= rfv_pkg::ED_W'($signed({1'b0, r2_eta})) * rfv_pkg::ED_W'(r2_d);
            r3_e2  <= r2_e2;
            r3_eix <= r2_eix;
            r3_eiy <= r2_eiy;
            r3_eiz <= r2_eiz;
            r3_nx  <= r2_nx;
            r3_ny  <= r2_ny;
            r3_nz  <= r2_nz;
        end
    end

    // Stage 4: one minus dot squared, scaled by eta squared.
    logic                              r4_vld;
    logic signed [rfv_pkg::U_W-1:0]    w_u;
    logic signed [rfv_pkg::P_W-1:0]    r4_p;
    logic signed [rfv_pkg::EDF_W-1:0]  r4_edf;
    logic signed [rfv_pkg::EI_W-1:0]   r4_eix, r4_eiy, r4_eiz;
    logic signed [rfv_pkg::IN_W-1:0]   r4_nx, r4_ny, r4_nz;

    assign w_u = rfv_pkg::U_W'(rfv_pkg::ONE)
               - rfv_pkg::U_W'(r3_dd >>> rfv_pkg::FRAC_BITS);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_p   <= rfv_pkg::P_W'($signed({1'b0, r3_e2})) * rfv_pkg::P_W'(w_u);
            r4_edf <= rfv_pkg::EDF_W'(r3_ed >>> rfv_pkg::FRAC_BITS);
            r4_eix <= r3_eix;
            r4_eiy <= r3_eiy;
            r4_eiz <= r3_eiz;
            r4_nx  <= r3_nx;
            r4_ny  <= r3_ny;
            r4_nz  <= r3_nz;
        end
    end

    // Stage 5: clamp the product, form k and the radicand.
    logic                              r5_vld;
    logic signed [rfv_pkg::PX_W-1:0]   w_px;
    logic signed [rfv_pkg::PX_W-1:0]   w_lim;
    logic signed [rfv_pkg::PX_W-1:0]   w_pcx;
    logic signed [rfv_pkg::PC_W-1:0]   w_pc;
    logic signed [rfv_pkg::K_W-1:0]    w_k;
    logic        [rfv_pkg::RAD_W-1:0]  r5_rad;
    rfv_pkg::t_sq_side                 r5_side;

    assign w_px  = rfv_pkg::PX_W'(r4_p);
    assign w_lim = rfv_pkg::PX_W'(rfv_pkg::PROD_LIM);

    always_comb begin
        if (w_px > w_lim) begin
            w_pcx = w_lim;
        end else if (w_px < -w_lim) begin
            w_pcx = -w_lim;
        end else begin
            w_pcx = w_px;
        end
    end

    assign w_pc = rfv_pkg::PC_W'(w_pcx);
    assign w_k  = rfv_pkg::K_W'(rfv_pkg::ONE)
                - rfv_pkg::K_W'(w_pc >>> rfv_pkg::FRAC_BITS);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r5_rad         <= rfv_pkg::RAD_W'(w_k[rfv_pkg::K_W-2:0]) << rfv_pkg::FRAC_BITS;
            r5_side.eta_ix <= r4_eix;
            r5_side.eta_iy <= r4_eiy;
            r5_side.eta_iz <= r4_eiz;
            r5_side.nx     <= r4_nx;
            r5_side.ny     <= r4_ny;
            r5_side.nz     <= r4_nz;
            r5_side.edf    <= r4_edf;
            r5_side.tir    <= w_k[rfv_pkg::K_W-1];
        end
    end

    // Square root of k.
    logic                              sq_vld;
    logic        [rfv_pkg::ROOT_W-1:0] sq_root;
    rfv_pkg::t_sq_side                 sq_side;

    rfv_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (r5_vld),
        .i_rad   (r5_rad),
        .i_side  (r5_side),
        .o_vld   (sq_vld),
        .o_root  (sq_root),
        .o_side  (sq_side)
    );

    // Stage 6: s = eta*dot + sqrt(k), then normal times s.
    logic                              r6_vld;
    logic signed [rfv_pkg::S_W-1:0]    w_s;
    logic signed [rfv_pkg::NS_W-1:0]   r6_nsx, r6_nsy, r6_nsz;
    logic signed [rfv_pkg::EI_W-1:0]   r6_eix, r6_eiy, r6_eiz;
    logic                              r6_tir;

    assign w_s = rfv_pkg::S_W'(sq_side.edf) + rfv_pkg::S_W'($signed({1'b0, sq_root}));

    always_ff @(posedge i_clk) begin
        if (en) begin
            r6_nsx <= rfv_pkg::NS_W'(sq_side.nx) * rfv_pkg::NS_W'(w_s);
            r6_nsy <= rfv_pkg::NS_W'(sq_side.ny) * rfv_pkg::NS_W'(w_s);
            r6_nsz <= rfv_pkg::NS_W'(sq_side.nz) * rfv_pkg::NS_W'(w_s);
            r6_eix <= sq_side.eta_ix;
            r6_eiy <= sq_side.eta_iy;
            r6_eiz <= sq_side.eta_iz;
            r6_tir <= sq_side.tir;
        end
    end

    // Output stage: difference, scale, saturate.
    logic signed [rfv_pkg::C_W-1:0]    w_cx, w_cy, w_cz;
    logic        [rfv_pkg::OUT_W:0]    w_sx, w_sy, w_sz;
    logic signed [rfv_pkg::OUT_W-1:0]  r_out_x, r_out_y, r_out_z;
    logic                              r_out_tir, r_out_clip;

    assign w_cx = rfv_pkg::C_W'(r6_eix) - rfv_pkg::C_W'(r6_nsx);
    assign w_cy = rfv_pkg::C_W'(r6_eiy) - rfv_pkg::C_W'(r6_nsy);
    assign w_cz = rfv_pkg::C_W'(r6_eiz) - rfv_pkg::C_W'(r6_nsz);
    assign w_sx = sat_c(rfv_pkg::CF_W'(w_cx >>> rfv_pkg::FRAC_BITS));
    assign w_sy = sat_c(rfv_pkg::CF_W'(w_cy >>> rfv_pkg::FRAC_BITS));
    assign w_sz = sat_c(rfv_pkg::CF_W'(w_cz >>> rfv_pkg::FRAC_BITS));

    always_ff @(posedge i_clk) begin
        if (en) begin
            if (r6_tir) begin
                r_out_x    <= '0;
                r_out_y    <= '0;
                r_out_z    <= '0;
                r_out_tir  <= 1'b1;
                r_out_clip <= 1'b0;
            end else begin
                r_out_x    <= w_sx[rfv_pkg::OUT_W-1:0];
                r_out_y    <= w_sy[rfv_pkg::OUT_W-1:0];
                r_out_z    <= w_sz[rfv_pkg::OUT_W-1:0];
                r_out_tir  <= 1'b0;
                r_out_clip <= w_sx[rfv_pkg::OUT_W] | w_sy[rfv_pkg::OUT_W]
                            | w_sz[rfv_pkg::OUT_W];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld    <= 1'b0;
            r2_vld    <= 1'b0;
            r3_vld    <= 1'b0;
            r4_vld    <= 1'b0;
            r5_vld    <= 1'b0;
            r6_vld    <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (en) begin
            r1_vld    <= i_in.valid;
            r2_vld    <= r1_vld;
            r3_vld    <= r2_vld;
            r4_vld    <= r3_vld;
            r5_vld    <= r4_vld;
            r6_vld    <= sq_vld;
            r_out_vld <= r6_vld;
        end
    end

    assign o_out.valid            = r_out_vld;
    assign o_out.refracted_x      = r_out_x;
    assign o_out.refracted_y      = r_out_y;
    assign o_out.refracted_z      = r_out_z;
    assign o_out.total_reflection = r_out_tir;
    assign o_out.clipped          = r_out_clip;

    `RFV_ASSERT_NEXT(a_accept_enters, i_clk, i_rst_n, i_in.valid && i_in.ready, r1_vld, "accepted transaction did not enter the pipeline")
    `RFV_ASSERT_NOW(a_stall_blocks, i_clk, i_rst_n, o_out.valid && !o_out.ready, !i_in.ready, "input taken while the output is stalled")
    `RFV_ASSERT_NOW(a_tir_zero, i_clk, i_rst_n, o_out.valid && o_out.total_reflection, o_out.refracted_x == '0 && o_out.refracted_y == '0 && o_out.refracted_z == '0 && !o_out.clipped, "total reflection result is not a clean zero vector")
    `RFV_ASSERT_NOW(a_clip_at_rail, i_clk, i_rst_n, o_out.valid && o_out.clipped, o_out.refracted_x[rfv_pkg::OUT_W-2:0] == '1 || o_out.refracted_x[rfv_pkg::OUT_W-2:0] == '0 || o_out.refracted_y[rfv_pkg::OUT_W-2:0] == '1 || o_out.refracted_y[rfv_pkg::OUT_W-2:0] == '0 || o_out.refracted_z[rfv_pkg::OUT_W-2:0] == '1 || o_out.refracted_z[rfv_pkg::OUT_W-2:0] == '0, "clipped result has no component at a rail")

endmodule

@@ tb/sv/tb_refract_vector.sv @@
// Self-checking testbench for the fixed-point vector refraction pipeline.
`timescale 1ns / 1ps

module tb_refract_vector;

    localparam int  WATCHDOG_LIMIT = 5000;
    localparam int  SETTLE_CYCLES  = 40;
    localparam int  LONG_HOLD      = 200;
    localparam int  REPORT_LIMIT   = 10;
    localparam int  Q_ONE          = 16384;
    localparam longint PROD_CAP    = 64'sd1 <<< 62;
    localparam longint OUT_HI      = (64'sd1 <<< (rfv_pkg::OUT_W - 1)) - 1;
    localparam longint OUT_LO      = -(64'sd1 <<< (rfv_pkg::OUT_W - 1));

    typedef struct {
        logic signed [rfv_pkg::IN_W-1:0] ix;
        logic signed [rfv_pkg::IN_W-1:0] iy;
        logic signed [rfv_pkg::IN_W-1:0] iz;
        logic signed [rfv_pkg::IN_W-1:0] nx;
        logic signed [rfv_pkg::IN_W-1:0] ny;
        logic signed [rfv_pkg::IN_W-1:0] nz;
        logic [rfv_pkg::ETA_W-1:0]       eta;
    } t_ray;

    typedef struct {
        logic signed [rfv_pkg::OUT_W-1:0] rx;
        logic signed [rfv_pkg::OUT_W-1:0] ry;
        logic signed [rfv_pkg::OUT_W-1:0] rz;
        logic                             tir;
        logic                             clip;
    } t_refraction;

    logic clk;
    logic rst_n;

    rfv_in_if  in_if ();
    rfv_out_if out_if ();

    refract_vector dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    t_refraction expected_refractions[$];
    int mismatch_count = 0;
    int idle_pct = 0;
    int stall_pct = 0;
    int hold_len = 0;
    int hold_id = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int quiet_cycles = 0;

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic longint unsigned int_sqrt(input longint unsigned x);
        longint unsigned root;
        longint unsigned b;
        root = 0;
        b = 64'd1 << 62;
        while (b > x) b >>= 2;
        while (b != 0) begin
            if (x >= root + b) begin
                x -= root + b;
                root = (root >> 1) + b;
            end else begin
                root >>= 1;
            end
            b >>= 2;
        end
        return root;
    endfunction

    function automatic t_refraction refract_predict(input t_ray r);
        longint iv[3];
        longint nv[3];
        longint comp[3];
        longint eta, one, dotw, d, u, e2, prod, k, root, s, lim;
        t_refraction res;
        res.rx = '0;
        res.ry = '0;
        res.rz = '0;
        res.tir = 1'b0;
        res.clip = 1'b0;
        iv[0] = longint'(r.ix);
        iv[1] = longint'(r.iy);
        iv[2] = longint'(r.iz);
        nv[0] = longint'(r.nx);
        nv[1] = longint'(r.ny);
        nv[2] = longint'(r.nz);
        eta = longint'({1'b0, r.eta});
        one = 64'sd1 <<< rfv_pkg::FRAC_BITS;
        dotw = iv[0] * nv[0] + iv[1] * nv[1] + iv[2] * nv[2];
        d = dotw >>> rfv_pkg::FRAC_BITS;
        u = one - ((d * d) >>> rfv_pkg::FRAC_BITS);
        e2 = (eta * eta) >>> rfv_pkg::FRAC_BITS;
        if (e2 == 0) begin
            prod = 0;
        end else begin
            lim = PROD_CAP / e2;
            if (u > lim) prod = PROD_CAP;
            else if (u < -lim) prod = -PROD_CAP;
            else prod = e2 * u;
        end
        k = one - (prod >>> rfv_pkg::FRAC_BITS);
        if (k < 0) begin
            res.tir = 1'b1;
            return res;
        end
        root = longint'(int_sqrt(longint'(k) << rfv_pkg::FRAC_BITS));
        s = ((eta * d) >>> rfv_pkg::FRAC_BITS) + root;
        for (int j = 0; j < 3; j++) begin
            comp[j] = (eta * iv[j] - nv[j] * s) >>> rfv_pkg::FRAC_BITS;
            if (comp[j] > OUT_HI) begin
                comp[j] = OUT_HI;
                res.clip = 1'b1;
            end else if (comp[j] < OUT_LO) begin
                comp[j] = OUT_LO;
                res.clip = 1'b1;
            end
        end
        res.rx = comp[0][rfv_pkg::OUT_W-1:0];
        res.ry = comp[1][rfv_pkg::OUT_W-1:0];
        res.rz = comp[2][rfv_pkg::OUT_W-1:0];
        return res;
    endfunction

    function automatic t_ray make_ray(input int ix, input int iy, input int iz,
                                      input int nx, input int ny, input int nz,
                                      input int eta);
        t_ray r;
        r.ix = 16'(ix);
        r.iy = 16'(iy);
        r.iz = 16'(iz);
        r.nx = 16'(nx);
        r.ny = 16'(ny);
        r.nz = 16'(nz);
        r.eta = 16'(eta);
        return r;
    endfunction

    function automatic int spread(input int m);
        return int'($urandom_range(2 * m)) - m;
    endfunction

    // Most rays are well formed: a bounded incident vector, a physical index ratio
    // and mostly a near-unit axis normal, so that both refraction and total
    // internal reflection occur often. The rest use raw 16-bit values.
    function automatic t_ray random_ray();
        t_ray r;
        int kind;
        int axis;
        int mag;
        kind = $urandom_range(9);
        if (kind < 4) begin
            r.ix = 16'($urandom);
            r.iy = 16'($urandom);
            r.iz = 16'($urandom);
            r.nx = 16'($urandom);
            r.ny = 16'($urandom);
            r.nz = 16'($urandom);
            r.eta = 16'($urandom);
        end else begin
            r.ix = 16'(spread(Q_ONE));
            r.iy = 16'(spread(Q_ONE));
            r.iz = 16'(spread(Q_ONE));
            if (kind < 8) begin
                axis = $urandom_range(2);
                mag = $urandom_range(1) ? Q_ONE : -Q_ONE;
                r.nx = 16'(spread(600));
                r.ny = 16'(spread(600));
                r.nz = 16'(spread(600));
                case (axis)
                    0: r.nx = 16'(mag + spread(300));
                    1: r.ny = 16'(mag + spread(300));
                    default: r.nz = 16'(mag + spread(300));
                endcase
            end else begin
                r.nx = 16'(spread(Q_ONE));
                r.ny = 16'(spread(Q_ONE));
                r.nz = 16'(spread(Q_ONE));
            end
            r.eta = 16'($urandom_range(40000, 8192));
        end
        return r;
    endfunction

    task automatic send_ray(input t_ray r);
        while ($urandom_range(99) < idle_pct) begin
            in_if.valid <= 1'b0;
            @(posedge clk);
        end
        in_if.valid      <= 1'b1;
        in_if.incident_x <= r.ix;
        in_if.incident_y <= r.iy;
        in_if.incident_z <= r.iz;
        in_if.normal_x   <= r.nx;
        in_if.normal_y   <= r.ny;
        in_if.normal_z   <= r.nz;
        in_if.eta        <= r.eta;
        do @(posedge clk); while (!in_if.ready);
        expected_refractions.push_back(refract_predict(r));
    endtask

    task automatic wait_drain();
        in_if.valid <= 1'b0;
        while (expected_refractions.size() != 0) @(posedge clk);
    endtask

    task automatic test_directed();
        idle_pct = 0;
        stall_pct = 0;
        send_ray(make_ray(0, 0, 0, 0, 0, 0, 0));
        send_ray(make_ray(0, 0, -Q_ONE, 0, 0, Q_ONE, Q_ONE));
        send_ray(make_ray(8000, -9000, 4000, 0, Q_ONE, 0, 0));
        send_ray(make_ray(8000, -9000, 4000, 0, Q_ONE, 0, 1));
        send_ray(make_ray(32767, 32767, 32767, 32767, 32767, 32767, 65535));
        send_ray(make_ray(-32768, -32768, -32768, -32768, -32768, -32768, 65535));
        send_ray(make_ray(32767, -32768, 32767, -32768, 32767, -32768, 65535));
        send_ray(make_ray(32767, 32767, 32767, -32768, -32768, -32768, 0));
        send_ray(make_ray(16000, 0, -3000, 0, 0, Q_ONE, 24576));
        send_ray(make_ray(Q_ONE, 0, 0, 0, 0, Q_ONE, Q_ONE));
        send_ray(make_ray(Q_ONE, 0, 0, 0, 0, Q_ONE, Q_ONE + 1));
        send_ray(make_ray(11585, -11585, 0, -Q_ONE, 0, 0, 10923));
        send_ray(make_ray(0, -11585, 11585, 0, Q_ONE, 0, 32768));
        send_ray(make_ray(-5000, 12000, -9000, 0, 0, -Q_ONE, 21845));
        send_ray(make_ray(0, 0, 0, 32767, -32768, 32767, 65535));
        send_ray(make_ray(-32768, 32767, -1, 1, -1, 0, 49152));
        wait_drain();
    endtask

    task automatic test_random_phase(input int send_idle, input int recv_stall,
                                     input int count);
        idle_pct = send_idle;
        stall_pct = recv_stall;
        repeat (count) send_ray(random_ray());
        wait_drain();
    endtask

    task automatic test_long_stall();
        idle_pct = 0;
        stall_pct = 0;
        hold_len <= LONG_HOLD;
        hold_id <= hold_id + 1;
        repeat (80) send_ray(random_ray());
        wait_drain();
    endtask

    task automatic test_sender_pause();
        idle_pct = 28;
        stall_pct = 28;
        repeat (2) begin
            repeat (40) send_ray(random_ray());
            wait_drain();
        end
    endtask

    always @(posedge clk) begin
        if (hold_id != hold_seen) begin
            hold_seen = hold_id;
            hold_left = hold_len;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            out_if.ready <= 1'b0;
        end else begin
            out_if.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge clk) begin : check_results
        t_refraction got;
        t_refraction want;
        if (rst_n && out_if.valid && out_if.ready) begin
            got.rx = out_if.refracted_x;
            got.ry = out_if.refracted_y;
            got.rz = out_if.refracted_z;
            got.tir = out_if.total_reflection;
            got.clip = out_if.clipped;
            if (expected_refractions.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT) begin
                    $display("unexpected transaction: x=%0d y=%0d z=%0d tir=%b clip=%b",
                             got.rx, got.ry, got.rz, got.tir, got.clip);
                end
            end else begin
                want = expected_refractions.pop_front();
                if (got.rx !== want.rx || got.ry !== want.ry || got.rz !== want.rz ||
                    got.tir !== want.tir || got.clip !== want.clip) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT) begin
                        $display("result error: expected x=%0d y=%0d z=%0d tir=%b clip=%b",
                                 want.rx, want.ry, want.rz, want.tir, want.clip);
                        $display("              got      x=%0d y=%0d z=%0d tir=%b clip=%b",
                                 got.rx, got.ry, got.rz, got.tir, got.clip);
                    end
                end
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
                quiet_cycles <= 0;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("refract_vector: mismatch");
                $finish;
            end
        end
    end

    initial begin
        rst_n            <= 1'b0;
        in_if.valid      <= 1'b0;
        in_if.incident_x <= '0;
        in_if.incident_y <= '0;
        in_if.incident_z <= '0;
        in_if.normal_x   <= '0;
        in_if.normal_y   <= '0;
        in_if.normal_z   <= '0;
        in_if.eta        <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random_phase(0, 0, 200);
        test_random_phase(66, 0, 200);
        test_random_phase(0, 66, 200);
        test_random_phase(28, 28, 200);
        test_long_stall();
        test_sender_pause();

        wait_drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (expected_refractions.size() != 0) begin
            $display("%0d expected transactions never arrived", expected_refractions.size());
        end
        if (mismatch_count == 0 && expected_refractions.size() == 0) begin
            $display("refract_vector: match");
        end else begin
            $display("refract_vector: mismatch");
        end
        $finish;
    end

endmodule
